// ===== src/spe_pkg.sv =====
// shared types and constants for the sparse product expansion block
package spe_pkg;

  localparam int ROW_W   = 16;
  localparam int COL_W   = 16;
  localparam int VALUE_W = 32;
  localparam int PROD_W  = 64;
  localparam int MODE_W  = 2;
  localparam int ENTRY_W = ROW_W + COL_W + VALUE_W;

  localparam int DEF_STORE_DEPTH = 64;
  localparam int DEF_INDEX_BITS  = 16;

  localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_EXPAND = 2'd2;

  typedef enum logic [1:0] {
    OP_CLEAR,
    OP_LOAD,
    OP_EXPAND,
    OP_NONE
  } op_t;

  typedef struct packed {
    op_t                 op;
    logic [ROW_W-1:0]    row;
    logic [COL_W-1:0]    col;
    logic [VALUE_W-1:0]  value;
  } item_t;

endpackage

// ===== src/spe_ram.sv =====
// generic single-write, single-read ram with registered read
module spe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                clk,
  input  logic                                we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                    wdata,
  input  logic                                re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                    rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/spe_front.sv =====
// front end: takes input items, classifies the mode and queues them
module spe_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [spe_pkg::MODE_W-1:0]      mode,
  input  logic [spe_pkg::ROW_W-1:0]       entry_row,
  input  logic [spe_pkg::COL_W-1:0]       entry_col,
  input  logic signed [spe_pkg::VALUE_W-1:0] entry_value,
  input  logic                            item_valid,
  output logic                            item_ready,
  output spe_pkg::item_t                  q_item,
  output logic                            q_valid,
  input  logic                            q_pop
);
  import spe_pkg::*;

  localparam int Q_DEPTH = 2;

  item_t      slot [Q_DEPTH];
  logic       wp;
  logic       rp;
  logic [1:0] fill;
  logic [1:0] fill_next;
  item_t      cls;
  logic       push;
  logic       pop;

  // classify the mode; meaningless codes are swallowed here
  always_comb begin
    cls.row   = entry_row;
    cls.col   = entry_col;
    cls.value = entry_value;
    case (mode)
      MODE_CLEAR:  cls.op = OP_CLEAR;
      MODE_LOAD:   cls.op = OP_LOAD;
      MODE_EXPAND: cls.op = OP_EXPAND;
      default:     cls.op = OP_NONE;
    endcase
  end

  assign item_ready = (fill != 2'(Q_DEPTH));
  assign q_valid    = (fill != 2'd0);
  assign q_item     = slot[rp];
  assign push       = item_valid && item_ready && (cls.op != OP_NONE);
  assign pop        = q_pop && q_valid;

  always_comb begin
    fill_next = fill;
    if (push && !pop) begin
      fill_next = fill + 2'd1;
    end else if (pop && !push) begin
      fill_next = fill - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wp] <= cls;
    end
    if (rst) begin
      wp   <= 1'b0;
      rp   <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      fill <= fill_next;
    end
  end

endmodule

// ===== src/spe_back.sv =====
// back end: runs clear, load and expand items against the entry store
module spe_back #(
  parameter int STORE_DEPTH = spe_pkg::DEF_STORE_DEPTH,
  parameter int INDEX_BITS  = spe_pkg::DEF_INDEX_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  spe_pkg::item_t                    q_item,
  input  logic                              q_valid,
  output logic                              q_pop,
  output logic [spe_pkg::ROW_W-1:0]         out_row,
  output logic [spe_pkg::COL_W-1:0]         out_col,
  output logic signed [spe_pkg::PROD_W-1:0] product,
  output logic                              last_of_run,
  output logic                              result_valid,
  input  logic                              result_ready
);
  import spe_pkg::*;

  localparam int AW       = STORE_DEPTH > 1 ? $clog2(STORE_DEPTH) : 1;
  localparam int CW       = $clog2(STORE_DEPTH + 1);
  localparam int CMP_BITS = INDEX_BITS < ROW_W ? INDEX_BITS : ROW_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(STORE_DEPTH);

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

  state_t                     state;
  logic [CW-1:0]              cnt;
  logic [CW-1:0]              ri;
  logic                       s1_vld;
  logic [ROW_W-1:0]           cur_row;
  logic [COL_W-1:0]           cur_col;
  logic [VALUE_W-1:0]         cur_value;
  logic                       pend_vld;
  logic [COL_W-1:0]           pend_col;
  logic signed [PROD_W-1:0]   pend_prod;

  logic                       adv;
  logic                       issue;
  logic                       drained;
  logic                       hit;
  logic                       emit;
  logic                       we;
  logic [ENTRY_W-1:0]         rdata;
  logic [ROW_W-1:0]           rd_row;
  logic [COL_W-1:0]           rd_col;
  logic [VALUE_W-1:0]         rd_val;
  logic signed [PROD_W-1:0]   mult;

  spe_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(cnt[AW-1:0]),
    .wdata({q_item.row, q_item.col, q_item.value}),
    .re   (issue),
    .raddr(ri[AW-1:0]),
    .rdata(rdata)
  );

  assign rd_row = rdata[ENTRY_W-1 -: ROW_W];
  assign rd_col = rdata[VALUE_W +: COL_W];
  assign rd_val = rdata[VALUE_W-1:0];

  assign adv     = !result_valid || result_ready;
  assign q_pop   = (state == S_IDLE) && q_valid;
  assign we      = q_pop && (q_item.op == OP_LOAD) && (cnt < DEPTH_C);
  assign issue   = (state == S_SCAN) && adv && (ri < cnt);
  assign drained = (state == S_SCAN) && !s1_vld && (ri == cnt);
  assign hit     = s1_vld && (rd_row[CMP_BITS-1:0] == cur_col[CMP_BITS-1:0]);
  assign emit    = adv && pend_vld && (hit || drained);
  assign mult    = $signed(cur_value) * $signed(rd_val);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      cnt          <= '0;
      ri           <= '0;
      s1_vld       <= 1'b0;
      pend_vld     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (emit) begin
        result_valid <= 1'b1;
      end else if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_pop) begin
            case (q_item.op)
              OP_CLEAR: cnt <= '0;
              OP_LOAD: begin
                if (cnt < DEPTH_C) begin
                  cnt <= cnt + CW'(1);
                end
              end
              OP_EXPAND: begin
                cur_row   <= q_item.row;
                cur_col   <= q_item.col;
                cur_value <= q_item.value;
                ri        <= '0;
                state     <= S_SCAN;
              end
              default: ;
            endcase
          end
        end
        S_SCAN: begin
          if (adv) begin
            s1_vld <= issue;
            if (issue) begin
              ri <= ri + CW'(1);
            end
            if (hit) begin
              // a later match shows the held term is not the last
              pend_vld  <= 1'b1;
              pend_col  <= rd_col;
              pend_prod <= mult;
              if (pend_vld) begin
                out_row      <= cur_row;
                out_col      <= pend_col;
                product      <= pend_prod;
                last_of_run  <= 1'b0;
              end
            end else if (drained) begin
              if (pend_vld) begin
                out_row      <= cur_row;
                out_col      <= pend_col;
                product      <= pend_prod;
                last_of_run  <= 1'b1;
              end
              pend_vld <= 1'b0;
              state    <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !s1_vld && !pend_vld)
    else $error("scan stage busy while idle");

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= DEPTH_C)
    else $error("entry count beyond store depth");

  a_ri_range: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> ri <= cnt)
    else $error("scan index past entry count");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    s1_vld && !adv |=> s1_vld && $stable(ri))
    else $error("scan moved during output stall");
`endif

endmodule

// ===== src/sparse_product_expansion.sv =====
// top level of the sparse product expansion block
// clear and load items are done in the back end as they leave the queue
// an expand item goes through the pop, a read of each stored entry (one read per cycle
// while the output does not stall), a compare and multiply stage and a flush
// at most one result per cycle; the store read port and output stalls set the pace
// reset empties the queue, zeroes the entry count and drops pending results;
// store contents are not cleared and there is no clearing pass
module sparse_product_expansion #(
  parameter int STORE_DEPTH = spe_pkg::DEF_STORE_DEPTH,
  parameter int INDEX_BITS  = spe_pkg::DEF_INDEX_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [spe_pkg::MODE_W-1:0]          mode,
  input  logic [spe_pkg::ROW_W-1:0]           entry_row,
  input  logic [spe_pkg::COL_W-1:0]           entry_col,
  input  logic signed [spe_pkg::VALUE_W-1:0]  entry_value,
  input  logic                                item_valid,
  output logic                                item_ready,
  output logic [spe_pkg::ROW_W-1:0]           out_row,
  output logic [spe_pkg::COL_W-1:0]           out_col,
  output logic signed [spe_pkg::PROD_W-1:0]   product,
  output logic                                last_of_run,
  output logic                                result_valid,
  input  logic                                result_ready
);
  import spe_pkg::*;

  // classified items waiting for the back end
  item_t q_item;
  logic  q_valid;
  logic  q_pop;

  // front end: mode decode and a two-item queue, so new items are taken
  // while an expand is still scanning or a result waits at the output
  spe_front u_front (
    .clk        (clk),
    .rst        (rst),
    .mode       (mode),
    .entry_row  (entry_row),
    .entry_col  (entry_col),
    .entry_value(entry_value),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .q_item     (q_item),
    .q_valid    (q_valid),
    .q_pop      (q_pop)
  );

  // back end: entry store in ram, scan sequencer, multiplier and output register;
  // each match is held back one step so the last of the run can be flagged
  spe_back #(
    .STORE_DEPTH(STORE_DEPTH),
    .INDEX_BITS (INDEX_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_item      (q_item),
    .q_valid     (q_valid),
    .q_pop       (q_pop),
    .out_row     (out_row),
    .out_col     (out_col),
    .product     (product),
    .last_of_run (last_of_run),
    .result_valid(result_valid),
    .result_ready(result_ready)
  );

endmodule

// ===== bench/tb_sparse_product_expansion.sv =====
// self-checking testbench for the sparse product expansion block
module tb_sparse_product_expansion;
  timeunit 1ns;
  timeprecision 1ps;

  import spe_pkg::*;

  // the mode that carries no operation, sent to prove it is ignored
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  localparam int STORE_DEPTH  = DEF_STORE_DEPTH;
  localparam int IDX_BITS     = DEF_INDEX_BITS;
  localparam int DIRECTED_N   = 21;
  localparam int RANDOM_ITEMS = 88;
  localparam int IDLE_PCT     = 23;
  // sized from the store depth so this covers the slowest expand item
  localparam int DRAIN_CYCLES = STORE_DEPTH + 16;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int SHOWN_ERRORS = 10;

  localparam logic [ROW_W-1:0] IDX_MASK =
    (IDX_BITS >= ROW_W) ? {ROW_W{1'b1}} : ROW_W'((1 << IDX_BITS) - 1);

  // how a stimulus row is checked: by the predictor, as giving no term, or against a typed result
  typedef enum logic [1:0] {
    CHECK_PREDICT,
    CHECK_SILENT,
    CHECK_SINGLE
  } check_kind_t;

  typedef struct {
    logic [MODE_W-1:0]  mode;
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   col;
    logic [VALUE_W-1:0] value;
    check_kind_t        kind;
    logic [ROW_W-1:0]   exp_row;
    logic [COL_W-1:0]   exp_col;
    logic [PROD_W-1:0]  exp_product;
  } stim_row_t;

  typedef struct {
    logic [ROW_W-1:0]         row;
    logic [COL_W-1:0]         col;
    logic signed [PROD_W-1:0] product;
    logic                     last;
  } term_t;

  logic                       clk;
  logic                       rst          = 1'b1;
  logic [MODE_W-1:0]          mode         = MODE_CLEAR;
  logic [ROW_W-1:0]           entry_row    = '0;
  logic [COL_W-1:0]           entry_col    = '0;
  logic signed [VALUE_W-1:0]  entry_value  = '0;
  logic                       item_valid   = 1'b0;
  logic                       item_ready;
  logic [ROW_W-1:0]           out_row;
  logic [COL_W-1:0]           out_col;
  logic signed [PROD_W-1:0]   product;
  logic                       last_of_run;
  logic                       result_valid;
  logic                       result_ready = 1'b0;

  // our own copy of the right-matrix entry store
  logic [ROW_W-1:0]   bank_row   [STORE_DEPTH];
  logic [COL_W-1:0]   bank_col   [STORE_DEPTH];
  logic [VALUE_W-1:0] bank_value [STORE_DEPTH];
  int                 bank_fill;

  // product terms still owed by the block, oldest first
  term_t awaited_terms[$];

  stim_row_t directed_rows [DIRECTED_N];

  int  errors        = 0;
  int  terms_seen    = 0;
  int  counted_items = 0;
  int  cycle_count   = 0;
  bit  steady_flow   = 1'b0;

  sparse_product_expansion dut (
    .clk          (clk),
    .rst          (rst),
    .mode         (mode),
    .entry_row    (entry_row),
    .entry_col    (entry_col),
    .entry_value  (entry_value),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .out_row      (out_row),
    .out_col      (out_col),
    .product      (product),
    .last_of_run  (last_of_run),
    .result_valid (result_valid),
    .result_ready (result_ready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // watchdog: a hung handshake ends the run as a failure
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic note_failure(input string msg);
    errors++;
    if (errors <= SHOWN_ERRORS) begin
      $display("%s", msg);
    end
  endtask

  // apply one accepted item to the store copy and work out the terms it causes;
  // keep_terms is cleared for table rows that are silent or whose result is typed in by hand
  task automatic absorb_item(input logic [MODE_W-1:0] m, input logic [ROW_W-1:0] r,
                             input logic [COL_W-1:0] c, input logic [VALUE_W-1:0] v,
                             input bit keep_terms);
    term_t                    run[$];
    term_t                    t;
    logic signed [VALUE_W-1:0] left_v;
    logic signed [VALUE_W-1:0] right_v;
    logic signed [PROD_W-1:0]  wide_l;
    logic signed [PROD_W-1:0]  wide_r;
    case (m)
      MODE_CLEAR: begin
        bank_fill = 0;
      end
      MODE_LOAD: begin
        // a load into a full store is dropped
        if (bank_fill < STORE_DEPTH) begin
          bank_row[bank_fill]   = r;
          bank_col[bank_fill]   = c;
          bank_value[bank_fill] = v;
          bank_fill++;
        end
      end
      MODE_EXPAND: begin
        left_v = v;
        wide_l = left_v;
        for (int i = 0; i < bank_fill; i++) begin
          if ((bank_row[i] & IDX_MASK) == (c & IDX_MASK)) begin
            right_v   = bank_value[i];
            wide_r    = right_v;
            t.row     = r;
            t.col     = bank_col[i];
            t.product = wide_l * wide_r;
            t.last    = 1'b0;
            run.push_back(t);
          end
        end
        // no match means no term, so no last flag either
        if (run.size() > 0) begin
          run[run.size()-1].last = 1'b1;
        end
        if (keep_terms) begin
          foreach (run[i]) awaited_terms.push_back(run[i]);
        end
      end
      default: begin
        // mode three carries nothing and leaves the store alone
      end
    endcase
  endtask

  // present one item, hold it until accepted, then record what it should cause
  task automatic send_item(input stim_row_t s);
    term_t t;
    while (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid  <= 1'b1;
    mode        <= s.mode;
    entry_row   <= s.row;
    entry_col   <= s.col;
    entry_value <= s.value;
    do @(posedge clk); while (!item_ready);
    absorb_item(s.mode, s.row, s.col, s.value, s.kind == CHECK_PREDICT);
    if (s.kind == CHECK_SINGLE) begin
      t.row     = s.exp_row;
      t.col     = s.exp_col;
      t.product = s.exp_product;
      t.last    = 1'b1;
      awaited_terms.push_back(t);
    end
    counted_items++;
  endtask

  function automatic stim_row_t make_row(input logic [MODE_W-1:0] m,
                                         input logic [ROW_W-1:0] r,
                                         input logic [COL_W-1:0] c,
                                         input logic [VALUE_W-1:0] v);
    stim_row_t s;
    s.mode        = m;
    s.row         = r;
    s.col         = c;
    s.value       = v;
    s.kind        = CHECK_PREDICT;
    s.exp_row     = '0;
    s.exp_col     = '0;
    s.exp_product = '0;
    return s;
  endfunction

  // indices mostly come from a small pool so that expands find matches
  function automatic logic [ROW_W-1:0] pick_index(input logic [ROW_W-1:0] pool [4]);
    if ($urandom_range(99) < 85) return pool[$urandom_range(3)];
    return ROW_W'($urandom);
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(15))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return VALUE_W'($urandom);
    endcase
  endfunction

  // stray items between the well-formed ones, mostly the unused mode
  task automatic maybe_noise();
    logic [MODE_W-1:0] m;
    if ($urandom_range(9) == 0) begin
      m = $urandom_range(1) ? MODE_UNUSED : MODE_W'($urandom);
      send_item(make_row(m, ROW_W'($urandom), COL_W'($urandom), VALUE_W'($urandom)));
    end
  endtask

  // one episode: usually a clear, a batch of loads, then a few expands;
  // the filling episode overruns the store with entries sharing one row
  task automatic run_episode(input bit fill);
    logic [ROW_W-1:0] pool [4];
    int               n_load;
    int               n_expand;
    logic [ROW_W-1:0] r;
    logic [COL_W-1:0] c;
    foreach (pool[i]) pool[i] = ROW_W'($urandom);
    if (fill || $urandom_range(4) != 0) begin
      send_item(make_row(MODE_CLEAR, ROW_W'($urandom), COL_W'($urandom), VALUE_W'($urandom)));
    end
    n_load = fill ? STORE_DEPTH + 3 : $urandom_range(1, 8);
    for (int i = 0; i < n_load; i++) begin
      if (!fill) maybe_noise();
      r = fill ? pool[0] : pick_index(pool);
      send_item(make_row(MODE_LOAD, r, COL_W'($urandom), pick_value()));
    end
    n_expand = $urandom_range(1, 4);
    for (int i = 0; i < n_expand; i++) begin
      if (!fill) maybe_noise();
      c = (fill && i == 0) ? pool[0] : pick_index(pool);
      send_item(make_row(MODE_EXPAND, ROW_W'($urandom), c, pick_value()));
    end
  endtask

  // result side: random back-pressure, and every accepted term checked in order
  always @(posedge clk) begin
    term_t want;
    result_ready <= steady_flow ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
    if (!rst && result_valid && result_ready) begin
      terms_seen <= terms_seen + 1;
      if (awaited_terms.size() == 0) begin
        note_failure($sformatf("term %0d unexpected: row %h col %h product %h last %b",
                               terms_seen, out_row, out_col, product, last_of_run));
      end else begin
        want = awaited_terms.pop_front();
        if (out_row !== want.row || out_col !== want.col ||
            product !== want.product || last_of_run !== want.last) begin
          note_failure($sformatf(
            "term %0d: expected row %h col %h product %h last %b, got %h %h %h %b",
            terms_seen, want.row, want.col, want.product, want.last,
            out_row, out_col, product, last_of_run));
        end
      end
    end
  end

  initial begin
    // directed table: typed results only where they are obvious
    directed_rows = '{
      // expand straight after reset: the store is empty
      '{MODE_EXPAND, 16'h0001, 16'h0000, 32'h0001_0000, CHECK_SILENT,
        16'h0000, 16'h0000, 64'h0},
      '{MODE_LOAD,   16'h0000, 16'hffff, 32'h8000_0000, CHECK_SILENT,
        16'h0000, 16'h0000, 64'h0},
      // most negative times most negative gives the largest product
      '{MODE_EXPAND, 16'hffff, 16'h0000, 32'h8000_0000, CHECK_SINGLE,
        16'hffff, 16'hffff, 64'h4000_0000_0000_0000},
      '{MODE_LOAD,   16'h0000, 16'h0000, 32'h7fff_ffff, CHECK_SILENT,
        16'h0000, 16'h0000, 64'h0},
      '{MODE_EXPAND, 16'h0000, 16'h0000, 32'h7fff_ffff, CHECK_PREDICT,
        16'h0000, 16'h0000, 64'h0},
      // expand with no matching stored row
      '{MODE_EXPAND, 16'h1234, 16'h0001, 32'h0000_0001, CHECK_SILENT,
        16'h0000, 16'h0000, 64'h0},
      '{MODE_UNUSED, 16'h0000, 16'h0000, 32'hffff_ffff, CHECK_SILENT,
        16'h0000, 16'h0000, 64'h0},
      '{MODE_EXPAND, 16'h0005, 16'h0000, 32'hffff_ffff, CHECK_PREDICT,
        16'h0000, 16'h0000, 64'h0},
      '{MODE_CLEAR,  16'hffff, 16'hffff, 32'hffff_ffff, CHECK_SILENT,
        16'h0000, 16'h0000, 64'h0},
      // cleared store gives nothing
      '{MODE_EXPAND, 16'h0003, 16'h0000, 32'h0001_0000, CHECK_SILENT,
        16'h0000, 16'h0000, 64'h0},
      '{MODE_LOAD,   16'hffff, 16'h1234, 32'h0001_0000, CHECK_SILENT,
        16'h0000, 16'h0000, 64'h0},
      '{MODE_LOAD,   16'h8000, 16'h0001, 32'hffff_0000, CHECK_SILENT,
        16'h0000, 16'h0000, 64'h0},
      '{MODE_LOAD,   16'hffff, 16'habcd, 32'h0000_8000, CHECK_SILENT,
        16'h0000, 16'h0000, 64'h0},
      '{MODE_EXPAND, 16'h0007, 16'hffff, 32'h0002_0000, CHECK_PREDICT,
        16'h0000, 16'h0000, 64'h0},
      // minus one times minus one in fixed point
      '{MODE_EXPAND, 16'h0009, 16'h8000, 32'hffff_0000, CHECK_SINGLE,
        16'h0009, 16'h0001, 64'h0000_0001_0000_0000},
      '{MODE_EXPAND, 16'h0000, 16'h7fff, 32'h0000_0000, CHECK_SILENT,
        16'h0000, 16'h0000, 64'h0},
      '{MODE_LOAD,   16'h0000, 16'h0000, 32'h0000_0000, CHECK_SILENT,
        16'h0000, 16'h0000, 64'h0},
      // zero value still yields a term
      '{MODE_EXPAND, 16'hffff, 16'h0000, 32'h7fff_ffff, CHECK_SINGLE,
        16'hffff, 16'h0000, 64'h0},
      '{MODE_UNUSED, 16'hffff, 16'hffff, 32'h7fff_ffff, CHECK_SILENT,
        16'h0000, 16'h0000, 64'h0},
      '{MODE_EXPAND, 16'h0001, 16'hffff, 32'h8000_0000, CHECK_PREDICT,
        16'h0000, 16'h0000, 64'h0},
      '{MODE_CLEAR,  16'h0000, 16'h0000, 32'h0000_0000, CHECK_SILENT,
        16'h0000, 16'h0000, 64'h0}
    };
    bank_fill = 0;

    // reset held from the start, once only
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) send_item(directed_rows[i]);

    // random part; the filling episode runs with no idling on either side
    counted_items = 0;
    for (int ep = 0; counted_items < RANDOM_ITEMS; ep++) begin
      steady_flow = (ep == 3);
      run_episode(ep == 3);
    end
    steady_flow = 1'b0;
    item_valid <= 1'b0;

    // drain, then allow a quiet spell for anything unexpected to show up
    while (awaited_terms.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0 && awaited_terms.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/spe_pkg.sv
src/spe_ram.sv
src/spe_front.sv
src/spe_back.sv
src/sparse_product_expansion.sv
bench/tb_sparse_product_expansion.sv
